[rtl/hysteresis_setpoint_stepper_defines.svh]
// Assertion macros for the hysteresis setpoint stepper.
// Included by the top level; no other dependencies.
`ifndef HYSTERESIS_SETPOINT_STEPPER_DEFINES_SVH
`define HYSTERESIS_SETPOINT_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hss assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define HSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hss assertion failed: next-cycle implication");

`endif

[rtl/hss_pkg.sv]
// Shared types and constants for the hysteresis setpoint stepper.
// No dependencies; used by every module of the block except hss_fifo.
`default_nettype none

package hss_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int CMD_DEPTH_DEFAULT  = 2;
   localparam int RSP_DEPTH_DEFAULT  = 2;

   // input event kinds
   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_SAMPLE    = 3'd1;
   localparam logic [2:0] KIND_ON        = 3'd2;
   localparam logic [2:0] KIND_OFF       = 3'd3;
   localparam logic [2:0] KIND_SET_STEP  = 3'd4;
   localparam logic [2:0] KIND_BAND_STEP = 3'd5;
   localparam logic [2:0] KIND_LIGHT     = 3'd6;

   // result causes
   localparam logic [2:0] CAUSE_ON     = 3'd0;
   localparam logic [2:0] CAUSE_OFF    = 3'd1;
   localparam logic [2:0] CAUSE_MANUAL = 3'd2;
   localparam logic [2:0] CAUSE_AUTO   = 3'd3;
   localparam logic [2:0] CAUSE_LIGHT  = 3'd4;

   // register indexes
   localparam logic [2:0] REG_INTERVAL   = 3'd0;
   localparam logic [2:0] REG_SP_MIN     = 3'd1;
   localparam logic [2:0] REG_SP_MAX     = 3'd2;
   localparam logic [2:0] REG_SP_DEFAULT = 3'd3;
   localparam logic [2:0] REG_LOW_BASE   = 3'd4;
   localparam logic [2:0] REG_HIGH_BASE  = 3'd5;
   localparam logic [2:0] REG_STRIDE     = 3'd6;
   localparam logic [2:0] REG_STEPS      = 3'd7;

   // reset values
   localparam logic [15:0] RST_INTERVAL   = 16'd300;
   localparam logic [4:0]  RST_SP_MIN     = 5'd24;
   localparam logic [4:0]  RST_SP_MAX     = 5'd28;
   localparam logic [4:0]  RST_SP_DEFAULT = 5'd24;
   localparam logic [11:0] RST_LOW_BASE   = 12'd234;
   localparam logic [11:0] RST_HIGH_BASE  = 12'd250;
   localparam logic [5:0]  RST_STRIDE     = 6'd2;
   localparam logic [3:0]  RST_STEPS      = 4'd6;
   localparam logic [4:0]  RST_SETPOINT   = 5'd24;
   localparam logic [2:0]  RST_BAND       = 3'd3;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_SAMPLE,
      OP_ON,
      OP_OFF,
      OP_SET_STEP,
      OP_BAND_STEP,
      OP_LIGHT,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [11:0] temp;
   } cmd_type;

   typedef struct packed {
      logic       power;
      logic [4:0] setpoint;
      logic       light;
      logic [2:0] cause;
   } res_type;

   typedef struct packed {
      logic [15:0] interval;
      logic [4:0]  sp_min;
      logic [4:0]  sp_max;
      logic [4:0]  sp_default;
      logic [11:0] low_base;
      logic [11:0] high_base;
      logic [5:0]  stride;
      logic [3:0]  steps;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/hysteresis_setpoint_stepper.sv]
// Top level of the hysteresis setpoint stepper: register port, front, queues, back.
// Depends on hss_pkg, hss_fifo, hss_front, hss_back and the defines header.
//
// Usage:
//  Events enter on the request queue port: drive req_kind / req_temperature_tenths
//  with push high; the transfer happens on a rising edge with push high and full low.
//  Commands go out on the response queue port: while empty is low the oldest command
//  sits on rsp_*, and pop high with empty low completes the transfer.
//  A command reaches rsp_* through the front stage register (loaded at the event
//  transfer edge), then the command queue, then the result queue.
//  Throughput: one event per cycle while the command queue has room; the back end
//  executes one command per cycle, limited only by space in the result queue.
//  Events that cause no command (ticks, band steps, ignored requests) leave nothing
//  on the response side.
//  If the receiver stalls, the result queue fills, the back end stops reading the
//  command queue, that fills, and full rises on the request side.
//  Reset (synchronous, active high) empties both queues, loads register defaults,
//  turns power and light off, sets the setpoint to 24, band index to 3, timer to 0.
//  Registers (APB, 4-byte stride) should only be written while the block is idle.
`default_nettype none

`include "hysteresis_setpoint_stepper_defines.svh"

module hysteresis_setpoint_stepper #(
   parameter int TIMER_BITS = hss_pkg::TIMER_BITS_DEFAULT,
   parameter int CMD_DEPTH  = hss_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH  = hss_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request queue
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [11:0] req_temperature_tenths,
   // response queue
   output logic                    empty,
   input  wire logic               pop,
   output logic                    rsp_power,
   output logic [4:0]              rsp_setpoint_degrees,
   output logic                    rsp_light,
   output logic [2:0]              rsp_cause,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   hss_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_wr;
   logic [2:0]       csr_idx;

   logic             cmd_wr, cmd_rd, cmd_empty, cmd_full;
   hss_pkg::cmd_type cmd_wr_data, cmd_rd_data;
   logic             res_wr, res_full;
   hss_pkg::res_type res_wr_data, res_rd_data;

   // ---------------- register port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            hss_pkg::REG_INTERVAL:   cfg_in.interval   = pwdata[15:0];
            hss_pkg::REG_SP_MIN:     cfg_in.sp_min     = pwdata[4:0];
            hss_pkg::REG_SP_MAX:     cfg_in.sp_max     = pwdata[4:0];
            hss_pkg::REG_SP_DEFAULT: cfg_in.sp_default = pwdata[4:0];
            hss_pkg::REG_LOW_BASE:   cfg_in.low_base   = pwdata[11:0];
            hss_pkg::REG_HIGH_BASE:  cfg_in.high_base  = pwdata[11:0];
            hss_pkg::REG_STRIDE:     cfg_in.stride     = pwdata[5:0];
            hss_pkg::REG_STEPS:      cfg_in.steps      = pwdata[3:0];
            default:                 cfg_in            = cfg_ff;
         endcase
      end
   end

   // readback, zero extended
   always_comb begin
      unique case (csr_idx)
         hss_pkg::REG_INTERVAL:   prdata = 32'(cfg_ff.interval);
         hss_pkg::REG_SP_MIN:     prdata = 32'(cfg_ff.sp_min);
         hss_pkg::REG_SP_MAX:     prdata = 32'(cfg_ff.sp_max);
         hss_pkg::REG_SP_DEFAULT: prdata = 32'(cfg_ff.sp_default);
         hss_pkg::REG_LOW_BASE:   prdata = 32'(cfg_ff.low_base);
         hss_pkg::REG_HIGH_BASE:  prdata = 32'(cfg_ff.high_base);
         hss_pkg::REG_STRIDE:     prdata = 32'(cfg_ff.stride);
         hss_pkg::REG_STEPS:      prdata = 32'(cfg_ff.steps);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval   <= hss_pkg::RST_INTERVAL;
         cfg_ff.sp_min     <= hss_pkg::RST_SP_MIN;
         cfg_ff.sp_max     <= hss_pkg::RST_SP_MAX;
         cfg_ff.sp_default <= hss_pkg::RST_SP_DEFAULT;
         cfg_ff.low_base   <= hss_pkg::RST_LOW_BASE;
         cfg_ff.high_base  <= hss_pkg::RST_HIGH_BASE;
         cfg_ff.stride     <= hss_pkg::RST_STRIDE;
         cfg_ff.steps      <= hss_pkg::RST_STEPS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- front: accept and classify ----------------
   hss_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_kind               (req_kind),
      .req_temperature_tenths (req_temperature_tenths),
      .cmd_wr                 (cmd_wr),
      .cmd_data               (cmd_wr_data),
      .cmd_full               (cmd_full)
   );

   // command queue decouples front and back
   hss_fifo #(
      .WIDTH ($bits(hss_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr),
      .wr_data (cmd_wr_data),
      .rd_en   (cmd_rd),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty),
      .full    (cmd_full)
   );

   // ---------------- back: execute ----------------
   hss_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_data  (cmd_rd_data),
      .cmd_empty (cmd_empty),
      .cmd_rd    (cmd_rd),
      .res_wr    (res_wr),
      .res_data  (res_wr_data),
      .res_full  (res_full)
   );

   // result queue doubles as the output register
   hss_fifo #(
      .WIDTH ($bits(hss_pkg::res_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_wr),
      .wr_data (res_wr_data),
      .rd_en   (pop),
      .rd_data (res_rd_data),
      .empty   (empty),
      .full    (res_full)
   );

   assign rsp_power            = res_rd_data.power;
   assign rsp_setpoint_degrees = res_rd_data.setpoint;
   assign rsp_light            = res_rd_data.light;
   assign rsp_cause            = res_rd_data.cause;

   // ---------------- checks ----------------
   // back end never executes into a full result queue
   `HSS_ASSERT_IMP(a_no_exec_when_full, clock, reset, res_full, !cmd_rd)
   // pending command with room downstream is always taken
   `HSS_ASSERT_IMP(a_back_drains, clock, reset, !cmd_empty && !res_full, cmd_rd)
   // a power off command always carries power low, power on power high
   `HSS_ASSERT_IMP(a_off_power, clock, reset,
      !empty && (rsp_cause == hss_pkg::CAUSE_OFF), !rsp_power)
   `HSS_ASSERT_IMP(a_on_power, clock, reset,
      !empty && (rsp_cause == hss_pkg::CAUSE_ON), rsp_power)
   // an executed command leaves the result queue non-empty when it writes
   `HSS_ASSERT_NXT(a_result_lands, clock, reset, res_wr, !empty)

endmodule

`default_nettype wire

[rtl/hss_fifo.sv]
// Small synchronous queue used for the command and result paths.
// No package dependencies.
`default_nettype none

module hss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/hss_front.sv]
// Front end: accepts events, classifies the kind and stages a command.
// Depends on hss_pkg.
`default_nettype none

module hss_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [11:0] req_temperature_tenths,
   output logic                    cmd_wr,
   output hss_pkg::cmd_type        cmd_data,
   input  wire logic               cmd_full
);

   logic             valid_ff, valid_in;
   hss_pkg::cmd_type cmd_ff, cmd_in;
   hss_pkg::op_type  op_dec;
   logic             can_load;

   always_comb begin
      unique case (req_kind)
         hss_pkg::KIND_TICK:      op_dec = hss_pkg::OP_TICK;
         hss_pkg::KIND_SAMPLE:    op_dec = hss_pkg::OP_SAMPLE;
         hss_pkg::KIND_ON:        op_dec = hss_pkg::OP_ON;
         hss_pkg::KIND_OFF:       op_dec = hss_pkg::OP_OFF;
         hss_pkg::KIND_SET_STEP:  op_dec = hss_pkg::OP_SET_STEP;
         hss_pkg::KIND_BAND_STEP: op_dec = hss_pkg::OP_BAND_STEP;
         hss_pkg::KIND_LIGHT:     op_dec = hss_pkg::OP_LIGHT;
         default:                 op_dec = hss_pkg::OP_NONE;
      endcase
   end

   assign cmd_wr   = valid_ff && !cmd_full;
   assign cmd_data = cmd_ff;
   assign can_load = !valid_ff || cmd_wr;
   assign full     = !can_load;

   // unused kinds are taken and dropped here
   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (can_load) begin
         valid_in    = push && (op_dec != hss_pkg::OP_NONE);
         cmd_in.op   = op_dec;
         cmd_in.temp = req_temperature_tenths;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

[rtl/hss_back.sv]
// Back end: holds power, setpoint, light, timer and band state and executes commands.
// Depends on hss_pkg.
`default_nettype none

module hss_back #(
   parameter int TIMER_BITS = hss_pkg::TIMER_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire hss_pkg::cfg_type cfg,
   input  wire hss_pkg::cmd_type cmd_data,
   input  wire logic             cmd_empty,
   output logic                  cmd_rd,
   output logic                  res_wr,
   output hss_pkg::res_type      res_data,
   input  wire logic             res_full
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic                  powered_ff, powered_in;
   logic [4:0]            setpoint_ff, setpoint_in;
   logic                  light_ff, light_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [2:0]            band_ff, band_in;

   logic [8:0]         shift;
   logic signed [12:0] lo_lim, hi_lim, temp_x;
   logic [4:0]         auto_sp;
   logic               interval_done;
   logic [3:0]         band_next;

   assign cmd_rd = !cmd_empty && !res_full;

   // band limits: base plus index times stride
   assign shift  = 9'(band_ff * cfg.stride);
   assign lo_lim = {cfg.low_base[11], cfg.low_base} + {4'b0000, shift};
   assign hi_lim = {cfg.high_base[11], cfg.high_base} + {4'b0000, shift};
   assign temp_x = {cmd_data.temp[11], cmd_data.temp};

   assign interval_done = !(CMP_W'(elapsed_ff) < CMP_W'(cfg.interval));
   assign band_next     = {1'b0, band_ff} + 4'd1;

   always_comb begin
      if ((temp_x > hi_lim) && (setpoint_ff > cfg.sp_min)) begin
         auto_sp = setpoint_ff - 5'd1;
      end else if ((temp_x < lo_lim) && (setpoint_ff < cfg.sp_max)) begin
         auto_sp = setpoint_ff + 5'd1;
      end else begin
         auto_sp = setpoint_ff;
      end
   end

   always_comb begin
      powered_in        = powered_ff;
      setpoint_in       = setpoint_ff;
      light_in          = light_ff;
      elapsed_in        = elapsed_ff;
      band_in           = band_ff;
      res_wr            = 1'b0;
      res_data.power    = powered_ff;
      res_data.setpoint = setpoint_ff;
      res_data.light    = light_ff;
      res_data.cause    = hss_pkg::CAUSE_LIGHT;
      if (cmd_rd) begin
         case (cmd_data.op)
            hss_pkg::OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            hss_pkg::OP_SAMPLE: begin
               if (powered_ff && interval_done) begin
                  elapsed_in = '0;
                  if (auto_sp != setpoint_ff) begin
                     setpoint_in       = auto_sp;
                     res_wr            = 1'b1;
                     res_data.power    = 1'b1;
                     res_data.setpoint = auto_sp;
                     res_data.cause    = hss_pkg::CAUSE_AUTO;
                  end
               end
            end
            hss_pkg::OP_ON: begin
               if (!powered_ff) begin
                  powered_in        = 1'b1;
                  setpoint_in       = cfg.sp_default;
                  elapsed_in        = '0;
                  res_wr            = 1'b1;
                  res_data.power    = 1'b1;
                  res_data.setpoint = cfg.sp_default;
                  res_data.cause    = hss_pkg::CAUSE_ON;
               end
            end
            hss_pkg::OP_OFF: begin
               if (powered_ff) begin
                  powered_in        = 1'b0;
                  res_wr            = 1'b1;
                  res_data.power    = 1'b0;
                  res_data.setpoint = cfg.sp_default;
                  res_data.cause    = hss_pkg::CAUSE_OFF;
               end
            end
            hss_pkg::OP_SET_STEP: begin
               if (powered_ff) begin
                  setpoint_in = (setpoint_ff >= cfg.sp_max) ? cfg.sp_min
                                                            : setpoint_ff + 5'd1;
                  res_wr            = 1'b1;
                  res_data.power    = 1'b1;
                  res_data.setpoint = setpoint_in;
                  res_data.cause    = hss_pkg::CAUSE_MANUAL;
               end
            end
            hss_pkg::OP_BAND_STEP: begin
               band_in = (band_next >= cfg.steps) ? 3'd0 : band_next[2:0];
            end
            hss_pkg::OP_LIGHT: begin
               light_in       = !light_ff;
               res_wr         = 1'b1;
               res_data.light = !light_ff;
               res_data.cause = hss_pkg::CAUSE_LIGHT;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         powered_ff  <= 1'b0;
         setpoint_ff <= hss_pkg::RST_SETPOINT;
         light_ff    <= 1'b0;
         elapsed_ff  <= '0;
         band_ff     <= hss_pkg::RST_BAND;
      end else begin
         powered_ff  <= powered_in;
         setpoint_ff <= setpoint_in;
         light_ff    <= light_in;
         elapsed_ff  <= elapsed_in;
         band_ff     <= band_in;
      end
   end

endmodule

`default_nettype wire

[tb/sv/tb_hysteresis_setpoint_stepper.sv]
// Self-checking testbench for hysteresis_setpoint_stepper: directed event script and
// randomized phases over several register settings and idle patterns.
// Depends on hss_pkg and the RTL of the block; stands alone otherwise.
`default_nettype none

module tb_hysteresis_setpoint_stepper;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer
   localparam int QUIET_CYCLES   = 8;    // outlasts the event-to-command path
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_EVENTS   = 126;
   localparam int SHORT_INTERVAL = 4;    // seconds between adjustments in the script

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NONE,
      CHK_FIXED
   } chk_mode_type;

   typedef struct packed {
      hss_pkg::op_type    op;
      logic signed [11:0] temp;
      int                 reps;
      chk_mode_type       chk;
      hss_pkg::res_type   fixed;
   } script_row_type;

   // ---------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic [2:0]         req_kind = hss_pkg::KIND_TICK;
   logic signed [11:0] req_temperature_tenths = '0;
   logic               pop = 1'b0;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   wire logic          full;
   wire logic          empty;
   wire logic          rsp_power;
   wire logic [4:0]    rsp_setpoint_degrees;
   wire logic          rsp_light;
   wire logic [2:0]    rsp_cause;
   wire logic [31:0]   prdata;
   wire logic          pready;

   hysteresis_setpoint_stepper dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_kind               (req_kind),
      .req_temperature_tenths (req_temperature_tenths),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_power              (rsp_power),
      .rsp_setpoint_degrees   (rsp_setpoint_degrees),
      .rsp_light              (rsp_light),
      .rsp_cause              (rsp_cause),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Thermostat model state: our own copy of registers and controller
   // ---------------------------------------------------------------
   hss_pkg::cfg_type cfg;
   logic             ac_powered;
   logic [4:0]       ac_setpoint;
   logic             ac_light;
   logic [15:0]      secs_elapsed;
   logic [2:0]       band_idx;

   hss_pkg::res_type expected_cmds [$];   // commands the block still owes us

   int  errors = 0;
   int  events_sent = 0;
   int  cmds_checked = 0;
   int  settings_used = 0;
   int  send_idle_pct = 0;       // chance of a sender gap per cycle
   int  pop_stall_pct = 0;       // chance of a receiver stall per cycle
   bit  calm = 1'b0;             // burst with no idling on either side
   int  idle_cycles = 0;

   // register settings for the random phases, in register index order:
   // interval, sp_min, sp_max, sp_default, low_base, high_base, stride, steps
   int cfg_sets [0:RAND_PHASES-1][0:7] = '{
      '{3, 16, 30, 20, 200, 220, 5, 8},
      '{0, 24, 28, 24, 234, 250, 2, 6},       // every powered sample may adjust
      '{1, 30, 16, 22, -400, 1250, 0, 1},     // min above max, flat band
      '{2, 0, 31, 31, -2048, 2047, 63, 0},    // field extremes, zero band steps
      '{4, 20, 25, 16, 1250, -400, 50, 15},   // inverted band, index wraps at 8
      '{1, 31, 31, 0, 0, 0, 31, 3},           // default below min
      '{2, 18, 26, 26, -100, 100, 40, 9},
      '{0, 16, 30, 30, 2047, -2048, 1, 7}
   };

   script_row_type script [0:24];

   // Advance the controller by one event; returns 1 when a command goes out.
   function automatic bit step_thermostat(input hss_pkg::op_type op,
                                          input logic signed [11:0] temp,
                                          output hss_pkg::res_type cmd);
      int         shift;
      int         lo;
      int         hi;
      int         nb;
      logic [4:0] nxt;
      bit         emitted;
      emitted = 1'b0;
      cmd = '0;
      case (op)
         hss_pkg::OP_TICK: begin
            if (secs_elapsed != '1)
               secs_elapsed = secs_elapsed + 16'd1;
         end
         hss_pkg::OP_SAMPLE: begin
            if (ac_powered && secs_elapsed >= cfg.interval) begin
               secs_elapsed = '0;
               shift = int'(band_idx) * int'(cfg.stride);
               lo = int'($signed(cfg.low_base)) + shift;
               hi = int'($signed(cfg.high_base)) + shift;
               nxt = ac_setpoint;
               // guards compare as written, so min > max can block both moves
               if (int'(temp) > hi && ac_setpoint > cfg.sp_min)
                  nxt = ac_setpoint - 5'd1;
               else if (int'(temp) < lo && ac_setpoint < cfg.sp_max)
                  nxt = ac_setpoint + 5'd1;
               if (nxt != ac_setpoint) begin
                  ac_setpoint = nxt;
                  cmd = {1'b1, ac_setpoint, ac_light, hss_pkg::CAUSE_AUTO};
                  emitted = 1'b1;
               end
            end
         end
         hss_pkg::OP_ON: begin
            if (!ac_powered) begin
               ac_powered = 1'b1;
               ac_setpoint = cfg.sp_default;
               secs_elapsed = '0;
               cmd = {1'b1, ac_setpoint, ac_light, hss_pkg::CAUSE_ON};
               emitted = 1'b1;
            end
         end
         hss_pkg::OP_OFF: begin
            // off command carries the default setpoint; the current one is kept
            if (ac_powered) begin
               ac_powered = 1'b0;
               cmd = {1'b0, cfg.sp_default, ac_light, hss_pkg::CAUSE_OFF};
               emitted = 1'b1;
            end
         end
         hss_pkg::OP_SET_STEP: begin
            if (ac_powered) begin
               ac_setpoint = (ac_setpoint >= cfg.sp_max) ? cfg.sp_min : ac_setpoint + 5'd1;
               cmd = {1'b1, ac_setpoint, ac_light, hss_pkg::CAUSE_MANUAL};
               emitted = 1'b1;
            end
         end
         hss_pkg::OP_BAND_STEP: begin
            // index is 3 bits: zero steps pins it at 0, more than 8 wraps at 8
            nb = int'(band_idx) + 1;
            band_idx = (nb >= int'(cfg.steps)) ? 3'd0 : 3'(nb);
         end
         hss_pkg::OP_LIGHT: begin
            ac_light = ~ac_light;
            cmd = {ac_powered, ac_setpoint, ac_light, hss_pkg::CAUSE_LIGHT};
            emitted = 1'b1;
         end
         default: ; // unused kind: ignored
      endcase
      return emitted;
   endfunction

   // One event transfer on the request queue, then book the expected command.
   task automatic feed_event(input hss_pkg::op_type op, input logic signed [11:0] temp,
                             input chk_mode_type chk, input hss_pkg::res_type fixed);
      hss_pkg::res_type cmd;
      bit               has_cmd;
      while (!calm && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= op;
      req_temperature_tenths <= temp;
      do @(posedge clock); while (full);
      has_cmd = step_thermostat(op, temp, cmd);
      if (chk == CHK_FIXED)
         expected_cmds.push_back(fixed);
      else if (chk == CHK_PREDICT && has_cmd)
         expected_cmds.push_back(cmd);
      events_sent++;
   endtask

   // Let every owed command drain, then allow for events still in flight
   // that produce nothing.
   task automatic settle_block();
      push <= 1'b0;
      while (expected_cmds.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; leaves psel up so writes can chain.
   task automatic write_reg(input logic [2:0] idx, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         hss_pkg::REG_INTERVAL:   cfg.interval   = 16'(value);
         hss_pkg::REG_SP_MIN:     cfg.sp_min     = 5'(value);
         hss_pkg::REG_SP_MAX:     cfg.sp_max     = 5'(value);
         hss_pkg::REG_SP_DEFAULT: cfg.sp_default = 5'(value);
         hss_pkg::REG_LOW_BASE:   cfg.low_base   = 12'(value);
         hss_pkg::REG_HIGH_BASE:  cfg.high_base  = 12'(value);
         hss_pkg::REG_STRIDE:     cfg.stride     = 6'(value);
         hss_pkg::REG_STEPS:      cfg.steps      = 4'(value);
         default: ;
      endcase
   endtask

   task automatic end_reg_access();
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Result side: random pop, field-by-field check, watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin : result_side
      hss_pkg::res_type want;
      if (reset) begin
         pop <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_cmds.size() == 0) begin
               $error("unexpected command: power %0d setpoint %0d light %0d cause %0d",
                      rsp_power, rsp_setpoint_degrees, rsp_light, rsp_cause);
               errors++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_power !== want.power) begin
                  $error("power: expected %0d, got %0d", want.power, rsp_power);
                  errors++;
               end
               if (rsp_setpoint_degrees !== want.setpoint) begin
                  $error("setpoint_degrees: expected %0d, got %0d",
                         want.setpoint, rsp_setpoint_degrees);
                  errors++;
               end
               if (rsp_light !== want.light) begin
                  $error("light: expected %0d, got %0d", want.light, rsp_light);
                  errors++;
               end
               if (rsp_cause !== want.cause) begin
                  $error("cause: expected %0d, got %0d", want.cause, rsp_cause);
                  errors++;
               end
               cmds_checked++;
            end
         end
         pop <= calm || ($urandom_range(99) >= pop_stall_pct);
         // bursts with no idling: enter rarely, leave a bit faster
         if (calm ? ($urandom_range(15) == 0) : ($urandom_range(63) == 0))
            calm <= !calm;
         if ((push && !full) || (pop && !empty) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d commands owed",
                     idle_cycles, expected_cmds.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      hss_pkg::op_type    op;
      logic signed [11:0] temp;
      int                 roll;
      int                 edge_val;

      // model reset state mirrors the block's reset
      cfg.interval   = hss_pkg::RST_INTERVAL;
      cfg.sp_min     = hss_pkg::RST_SP_MIN;
      cfg.sp_max     = hss_pkg::RST_SP_MAX;
      cfg.sp_default = hss_pkg::RST_SP_DEFAULT;
      cfg.low_base   = hss_pkg::RST_LOW_BASE;
      cfg.high_base  = hss_pkg::RST_HIGH_BASE;
      cfg.stride     = hss_pkg::RST_STRIDE;
      cfg.steps      = hss_pkg::RST_STEPS;
      ac_powered   = 1'b0;
      ac_setpoint  = hss_pkg::RST_SETPOINT;
      ac_light     = 1'b0;
      secs_elapsed = '0;
      band_idx     = hss_pkg::RST_BAND;

      // Directed script on reset registers, except a short interval so the
      // tick runs stay brief: band index 3 gives limits 240..256.
      // Fixed rows are read straight off the reset state; the rest go through
      // the model.
      script = '{
         // light toggles while off, reports power off
         '{hss_pkg::OP_LIGHT, 12'sd0, 1, CHK_FIXED,
           {1'b0, 5'd24, 1'b1, hss_pkg::CAUSE_LIGHT}},
         // manual step, power off, sample: all ignored while off
         '{hss_pkg::OP_SET_STEP,  12'sd0,   1, CHK_NONE, '0},
         '{hss_pkg::OP_OFF,       12'sd0,   1, CHK_NONE, '0},
         '{hss_pkg::OP_SAMPLE,    12'sh7FF, 1, CHK_NONE, '0},
         '{hss_pkg::OP_ON, 12'sd0, 1, CHK_FIXED,
           {1'b1, 5'd24, 1'b1, hss_pkg::CAUSE_ON}},
         '{hss_pkg::OP_ON,        12'sd0,   1, CHK_NONE, '0},
         // sample before the interval has run: nothing
         '{hss_pkg::OP_SAMPLE,    12'sh800, 1, CHK_NONE, '0},
         '{hss_pkg::OP_TICK,      12'sd0,   SHORT_INTERVAL, CHK_NONE, '0},
         '{hss_pkg::OP_SAMPLE,    12'sh800, 1, CHK_PREDICT, '0},
         // counter restarted by the last adjustment
         '{hss_pkg::OP_SAMPLE,    12'sh800, 1, CHK_NONE, '0},
         '{hss_pkg::OP_TICK,      12'sd0,   SHORT_INTERVAL, CHK_NONE, '0},
         '{hss_pkg::OP_SAMPLE,    12'sh7FF, 1, CHK_PREDICT, '0},
         '{hss_pkg::OP_TICK,      12'sd0,   SHORT_INTERVAL, CHK_NONE, '0},
         // already at min: counter restarts, no command
         '{hss_pkg::OP_SAMPLE,    12'sh7FF, 1, CHK_PREDICT, '0},
         '{hss_pkg::OP_SET_STEP,  12'sd0,   4, CHK_PREDICT, '0},
         // at max the manual step wraps to min
         '{hss_pkg::OP_SET_STEP,  12'sd0,   1, CHK_PREDICT, '0},
         // band 3 -> 4 -> 5 -> wraps to 0 at six steps
         '{hss_pkg::OP_BAND_STEP, 12'sd0,   3, CHK_NONE, '0},
         '{hss_pkg::OP_TICK,      12'sd0,   SHORT_INTERVAL, CHK_NONE, '0},
         // exactly on the low limit: no move
         '{hss_pkg::OP_SAMPLE,    12'sd234, 1, CHK_PREDICT, '0},
         '{hss_pkg::OP_TICK,      12'sd0,   SHORT_INTERVAL, CHK_NONE, '0},
         '{hss_pkg::OP_SAMPLE,    12'sd233, 1, CHK_PREDICT, '0},
         // unused kind code is dropped
         '{hss_pkg::OP_NONE,      12'shFFF, 1, CHK_NONE, '0},
         // power off reports the default setpoint
         '{hss_pkg::OP_OFF, 12'sd0, 1, CHK_FIXED,
           {1'b0, 5'd24, 1'b1, hss_pkg::CAUSE_OFF}},
         '{hss_pkg::OP_LIGHT,     12'sd0,   1, CHK_PREDICT, '0},
         '{hss_pkg::OP_ON, 12'sd0, 1, CHK_FIXED,
           {1'b1, 5'd24, 1'b0, hss_pkg::CAUSE_ON}}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_reg(hss_pkg::REG_INTERVAL, SHORT_INTERVAL);
      end_reg_access();

      foreach (script[i])
         for (int r = 0; r < script[i].reps; r++)
            feed_event(script[i].op, script[i].temp, script[i].chk, script[i].fixed);
      settle_block();

      // Random phases: one register setting each, idle pattern rotates
      // through none / sender gaps / receiver stalls / both.
      for (int p = 0; p < RAND_PHASES; p++) begin
         for (int r = 0; r < 8; r++)
            write_reg(3'(r), cfg_sets[p][r]);
         end_reg_access();
         settings_used++;
         case (p % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 51; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 51; end
            default: begin send_idle_pct = 20; pop_stall_pct = 20; end
         endcase
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            // ticks and samples dominate so the interval is actually reached
            roll = $urandom_range(99);
            if (roll < 30)      op = hss_pkg::OP_TICK;
            else if (roll < 58) op = hss_pkg::OP_SAMPLE;
            else if (roll < 66) op = hss_pkg::OP_ON;
            else if (roll < 71) op = hss_pkg::OP_OFF;
            else if (roll < 80) op = hss_pkg::OP_SET_STEP;
            else if (roll < 87) op = hss_pkg::OP_BAND_STEP;
            else if (roll < 95) op = hss_pkg::OP_LIGHT;
            else                op = hss_pkg::OP_NONE;
            // mostly hover around a band limit, sometimes any 12-bit value
            if ($urandom_range(3) == 0) begin
               temp = 12'($urandom);
            end else begin
               edge_val = ($urandom_range(1) != 0) ? int'($signed(cfg.high_base))
                                                   : int'($signed(cfg.low_base));
               edge_val = edge_val + int'(band_idx) * int'(cfg.stride)
                          + int'($urandom_range(8)) - 4;
               temp = 12'(edge_val);
            end
            feed_event(op, temp, CHK_PREDICT, '0);
         end
         settle_block();
      end

      $display("Sent %0d events over %0d register settings plus reset values,",
               events_sent, settings_used);
      $display("checked %0d commands with every idle pattern.", cmds_checked);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
